// ===== rtl/mjo_pkg.sv =====
// ----------------------------------------------------------------------------
// Miter join offset package
// Item types, pipeline depths and the per-step functions shared by the
// square root, divider and unit vector pipelines.
// ----------------------------------------------------------------------------
package mjo_pkg;

   localparam int ISQRT_STEPS = 32;
   localparam int DIV_STEPS   = 34;
   localparam int UNIT_LAT    = 4 + ISQRT_STEPS + 1 + DIV_STEPS + 1;
   localparam int UNIT_BITS   = 30;

   localparam logic signed [63:0] NUDGE_Q30 = 64'sd1073742;

   typedef struct packed {
      logic signed [31:0] first_dir_x;
      logic signed [31:0] first_dir_y;
      logic signed [31:0] second_dir_x;
      logic signed [31:0] second_dir_y;
      logic signed [31:0] half_width;
   } req_type;

   typedef struct packed {
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic [63:0] v;
      logic [63:0] r;
   } sqrt_state_type;

   typedef struct packed {
      logic [63:0]          rem;
      logic [DIV_STEPS-1:0] q;
   } div_state_type;

   typedef struct packed {
      logic        flag;
      logic [31:0] val;
   } clamp_type;

   // one bit pair of the digit-by-digit square root
   function automatic sqrt_state_type sqrt_step(input logic [63:0] v, input logic [63:0] r,
                                                input int step);
      logic [63:0]    bitv;
      sqrt_state_type s;
      bitv = 64'd1 << (62 - 2 * step);
      if (v >= r + bitv) begin
         s.v = v - (r + bitv);
         s.r = (r >> 1) + bitv;
      end else begin
         s.v = v;
         s.r = r >> 1;
      end
      return s;
   endfunction

   // one quotient bit of restoring division
   function automatic div_state_type div_step(input logic [63:0] rem,
                                              input logic [DIV_STEPS-1:0] q,
                                              input logic [31:0] den, input int sh);
      logic [65:0]   d;
      div_state_type s;
      d = {34'd0, den} << sh;
      s.rem = rem;
      s.q   = q;
      if ({2'b00, rem} >= d) begin
         s.rem   = rem - d[63:0];
         s.q[sh] = 1'b1;
      end
      return s;
   endfunction

   // left shift that brings bit 30 to one
   function automatic logic [4:0] lead_zeros31(input logic [30:0] m);
      logic [4:0] s;
      s = 5'd0;
      for (int i = 0; i < 31; i++) begin
         if (m[i]) s = 5'(30 - i);
      end
      return s;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [32:0] v);
      logic [32:0] t;
      t = v[32] ? -v : v;
      return t[31:0];
   endfunction

   function automatic logic signed [32:0] round_q30(input logic signed [63:0] v);
      logic [63:0]        m;
      logic [63:0]        r;
      logic signed [32:0] t;
      m = v[63] ? -v : v;
      r = (m + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
      t = r[32:0];
      return v[63] ? -t : t;
   endfunction

   function automatic clamp_type clamp_out(input logic [33:0] m, input logic neg);
      clamp_type c;
      c.flag = 1'b0;
      if (neg) begin
         if (m > 34'h0_8000_0000) begin
            c.flag = 1'b1;
            c.val  = 32'h8000_0000;
         end else begin
            c.val = -m[31:0];
         end
      end else begin
         if (m > 34'h0_7FFF_FFFF) begin
            c.flag = 1'b1;
            c.val  = 32'h7FFF_FFFF;
         end else begin
            c.val = m[31:0];
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/mjo_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined square root
// Floor square root of a 64-bit value, one root bit per register stage.
// ----------------------------------------------------------------------------
module mjo_isqrt import mjo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] in_value,
   output logic        out_valid,
   output logic [31:0] out_root
);

   sqrt_state_type st_ff  [ISQRT_STEPS];
   sqrt_state_type st_in  [ISQRT_STEPS];
   logic           vld_ff [ISQRT_STEPS];

   always_comb begin
      st_in[0] = sqrt_step(in_value, 64'd0, 0);
      for (int i = 1; i < ISQRT_STEPS; i++) begin
         st_in[i] = sqrt_step(st_ff[i-1].v, st_ff[i-1].r, i);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ISQRT_STEPS; i++) st_ff[i] <= st_in[i];
      if (reset) begin
         for (int i = 0; i < ISQRT_STEPS; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < ISQRT_STEPS; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   assign out_valid = vld_ff[ISQRT_STEPS-1];
   assign out_root  = st_ff[ISQRT_STEPS-1].r[31:0];

endmodule

// ===== rtl/mjo_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider
// 64 by 32 bit unsigned division, one quotient bit per stage, with a flag
// for quotients that do not fit (a zero divisor always flags).
// ----------------------------------------------------------------------------
module mjo_div import mjo_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [63:0]          in_num,
   input  logic [31:0]          in_den,
   output logic                 out_valid,
   output logic [DIV_STEPS-1:0] out_quot,
   output logic                 out_ovf
);

   div_state_type st_ff  [DIV_STEPS];
   div_state_type st_in  [DIV_STEPS];
   logic [31:0]   den_ff [DIV_STEPS];
   logic          ovf_ff [DIV_STEPS];
   logic          vld_ff [DIV_STEPS];
   logic          ovf_in;

   always_comb begin
      ovf_in   = {2'b00, in_num} >= {in_den, 34'd0};
      st_in[0] = div_step(in_num, '0, in_den, DIV_STEPS - 1);
      for (int i = 1; i < DIV_STEPS; i++) begin
         st_in[i] = div_step(st_ff[i-1].rem, st_ff[i-1].q, den_ff[i-1], DIV_STEPS - 1 - i);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_STEPS; i++) st_ff[i] <= st_in[i];
      den_ff[0] <= in_den;
      ovf_ff[0] <= ovf_in;
      for (int i = 1; i < DIV_STEPS; i++) begin
         den_ff[i] <= den_ff[i-1];
         ovf_ff[i] <= ovf_ff[i-1];
      end
      if (reset) begin
         for (int i = 0; i < DIV_STEPS; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < DIV_STEPS; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_quot  = st_ff[DIV_STEPS-1].q;
   assign out_ovf   = ovf_ff[DIV_STEPS-1];

endmodule

// ===== rtl/mjo_unit.sv =====
// ----------------------------------------------------------------------------
// Unit vector pipeline
// Scales a vector into Q2.30 unit length: normalizing shift, squares,
// square root, then one rounded divide per component.
// ----------------------------------------------------------------------------
module mjo_unit import mjo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [32:0] in_x,
   input  logic signed [32:0] in_y,
   output logic               out_valid,
   output logic signed [31:0] out_ux,
   output logic signed [31:0] out_uy
);

   typedef struct packed {
      logic [30:0] mx;
      logic [30:0] my;
      logic        sx;
      logic        sy;
      logic        zero;
   } sq_side_type;

   typedef struct packed {
      logic sx;
      logic sy;
      logic zero;
   } dv_side_type;

   // stage 1: magnitudes
   logic [31:0] mx1_ff, my1_ff;
   logic        sx1_ff, sy1_ff, vld1_ff;
   // stage 2: normalized
   logic [31:0] m2, nx2, ny2;
   logic [4:0]  sh2;
   sq_side_type s2_in, s2_ff;
   logic        vld2_ff;
   // stage 3: squares
   logic [61:0] sqx3_ff, sqy3_ff;
   sq_side_type s3_ff;
   logic        vld3_ff;
   // stage 4: sum of squares
   logic [63:0] sum4_ff;
   sq_side_type s4_ff;
   logic        vld4_ff;
   // root
   logic        sqrt_vld;
   logic [31:0] sqrt_len;
   sq_side_type sq_dly_ff [ISQRT_STEPS];
   // stage 5: numerators
   logic [63:0] numx5_ff, numy5_ff;
   logic [31:0] len5_ff;
   dv_side_type s5_ff;
   logic        vld5_ff;
   // divide
   logic                 divx_vld, divy_vld, divx_ovf, divy_ovf;
   logic [DIV_STEPS-1:0] qx, qy;
   dv_side_type          dv_dly_ff [DIV_STEPS];
   dv_side_type          s6;
   // stage 6: output
   logic signed [31:0]   ux6_in, uy6_in, ux6_ff, uy6_ff;
   logic                 vld6_ff;

   always_comb begin
      m2  = (mx1_ff > my1_ff) ? mx1_ff : my1_ff;
      sh2 = lead_zeros31(m2[30:0]);
      if (m2[31]) begin
         nx2 = mx1_ff >> 1;
         ny2 = my1_ff >> 1;
      end else begin
         nx2 = mx1_ff << sh2;
         ny2 = my1_ff << sh2;
      end
      s2_in.mx   = nx2[30:0];
      s2_in.my   = ny2[30:0];
      s2_in.sx   = sx1_ff;
      s2_in.sy   = sy1_ff;
      s2_in.zero = (m2 == 32'd0);
   end

   always_ff @(posedge clock) begin
      mx1_ff  <= mag32(in_x);
      my1_ff  <= mag32(in_y);
      sx1_ff  <= in_x[32];
      sy1_ff  <= in_y[32];
      s2_ff   <= s2_in;
      sqx3_ff <= s2_ff.mx * s2_ff.mx;
      sqy3_ff <= s2_ff.my * s2_ff.my;
      s3_ff   <= s2_ff;
      sum4_ff <= 64'(sqx3_ff) + 64'(sqy3_ff);
      s4_ff   <= s3_ff;
      sq_dly_ff[0] <= s4_ff;
      for (int i = 1; i < ISQRT_STEPS; i++) sq_dly_ff[i] <= sq_dly_ff[i-1];
      numx5_ff <= {3'd0, sq_dly_ff[ISQRT_STEPS-1].mx, 30'd0} + 64'(sqrt_len >> 1);
      numy5_ff <= {3'd0, sq_dly_ff[ISQRT_STEPS-1].my, 30'd0} + 64'(sqrt_len >> 1);
      len5_ff  <= sqrt_len;
      s5_ff.sx   <= sq_dly_ff[ISQRT_STEPS-1].sx;
      s5_ff.sy   <= sq_dly_ff[ISQRT_STEPS-1].sy;
      s5_ff.zero <= sq_dly_ff[ISQRT_STEPS-1].zero;
      dv_dly_ff[0] <= s5_ff;
      for (int i = 1; i < DIV_STEPS; i++) dv_dly_ff[i] <= dv_dly_ff[i-1];
      ux6_ff <= ux6_in;
      uy6_ff <= uy6_in;
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= sqrt_vld;
         vld6_ff <= divx_vld & divy_vld;
      end
   end

   mjo_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld4_ff),
      .in_value  (sum4_ff),
      .out_valid (sqrt_vld),
      .out_root  (sqrt_len)
   );

   mjo_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld5_ff),
      .in_num    (numx5_ff),
      .in_den    (len5_ff),
      .out_valid (divx_vld),
      .out_quot  (qx),
      .out_ovf   (divx_ovf)
   );

   mjo_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld5_ff),
      .in_num    (numy5_ff),
      .in_den    (len5_ff),
      .out_valid (divy_vld),
      .out_quot  (qy),
      .out_ovf   (divy_ovf)
   );

   // quotients never exceed 2^30 for a nonzero vector
   always_comb begin
      s6 = dv_dly_ff[DIV_STEPS-1];
      if (s6.zero || divx_ovf || divy_ovf) begin
         ux6_in = '0;
         uy6_in = '0;
      end else begin
         ux6_in = s6.sx ? -$signed(qx[31:0]) : $signed(qx[31:0]);
         uy6_in = s6.sy ? -$signed(qy[31:0]) : $signed(qy[31:0]);
      end
   end

   assign out_valid = vld6_ff;
   assign out_ux    = ux6_ff;
   assign out_uy    = uy6_ff;

endmodule

// ===== rtl/miter_join_offset.sv =====
// ----------------------------------------------------------------------------
// Miter join offset
// Offset vector of the miter corner at a polyline joint, from the incoming
// and outgoing directions and the half width, all signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_item and raise start for one cycle per item. busy is always
//   low, so an item is taken at every edge where start is high; a new item
//   may follow in every cycle.
//   Each item gives one result on rsp_item, marked by rsp_valid for exactly
//   one cycle. Results leave in the order the items came in; the receiver
//   must take them as they come, nothing is held back. Throughput is one
//   item per cycle. The path runs through four unit vector pipelines (72
//   stages each, two pairs in series), one 32-stage square root and two
//   34-stage dividers in parallel, each one bit per stage.
//   Synchronous reset drops all items in flight; no result appears for
//   them. The block is ready again in the cycle after reset falls.
// ----------------------------------------------------------------------------
module miter_join_offset import mjo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   typedef struct packed {
      logic signed [31:0] hw;
      logic               fz;
   } side_a_type;

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic               opp;
      logic               flip;
      logic [31:0]        ml;
      logic               fz;
      logic [31:0]        zres_x;
      logic [31:0]        zres_y;
      logic               zflag;
   } side_b_type;

   typedef struct packed {
      logic [63:0] mm_x;
      logic [63:0] mm_y;
      logic        neg_x;
      logic        neg_y;
      logic        kz_x;
      logic        kz_y;
      logic        fz;
      logic [31:0] zres_x;
      logic [31:0] zres_y;
      logic        zflag;
   } side_c_type;

   typedef struct packed {
      logic        neg_x;
      logic        neg_y;
      logic        kz_x;
      logic        kz_y;
      logic        fz;
      logic [31:0] zres_x;
      logic [31:0] zres_y;
      logic        zflag;
   } side_d_type;

   // T0: input register
   req_type            in_ff;
   logic               vld0_ff;
   side_a_type         a_dly_ff [UNIT_LAT];
   // first unit pair
   logic               ua_vld, ub_vld;
   logic signed [31:0] ua_x, ua_y, ub_x, ub_y;
   // T1
   logic signed [31:0] ax1_ff, ay1_ff, bx1_ff, by1_ff;
   logic [31:0]        ml1_ff;
   logic               fz1_ff, opp1_ff, zsx1_ff, zsy1_ff, vld1_ff;
   logic signed [63:0] nxp1_ff, nyp1_ff;
   logic [63:0]        zpx1_ff, zpy1_ff;
   logic [31:0]        ml1_in;
   logic signed [32:0] nay1;
   // T2
   logic signed [32:0] apx2_ff, apy2_ff;
   logic signed [31:0] ax2_ff, ay2_ff, bx2_ff, by2_ff;
   logic [31:0]        ml2_ff, zrx2_ff, zry2_ff;
   logic               fz2_ff, opp2_ff, zfl2_ff, vld2_ff;
   logic [31:0]        zmx2, zmy2;
   clamp_type          zcx2, zcy2;
   logic [63:0]        zrx_sum, zry_sum;
   // T3
   logic signed [32:0] apx3_ff, apy3_ff, smx3_ff, smy3_ff;
   logic signed [63:0] cxa3_ff, cxb3_ff;
   side_b_type         s3_ff, b3_in;
   logic               vld3_ff;
   side_b_type         b_dly_ff [UNIT_LAT];
   side_b_type         sb;
   // second unit pair
   logic               uc_vld, ud_vld;
   logic signed [31:0] uc_x, uc_y, ud_x, ud_y;
   // T4
   logic signed [31:0] anx4, any4;
   logic signed [32:0] dx4_ff, dy4_ff;
   logic [31:0]        mux4_ff, muy4_ff, mux4_in, muy4_in;
   side_c_type         c4_ff, c4_in;
   logic [31:0]        ml4_ff;
   logic               vld4_ff;
   // T5
   logic [63:0]        sqx5_ff, sqy5_ff;
   logic [31:0]        mdx5, mdy5;
   side_c_type         c5_ff, c5_in;
   logic               vld5_ff;
   // T6
   logic [63:0]        sum6_ff;
   side_c_type         c6_ff;
   logic               vld6_ff;
   side_c_type         c_dly_ff [ISQRT_STEPS];
   side_c_type         sc;
   logic               g_vld;
   logic [31:0]        g_root;
   // T7
   logic [63:0]        numx7_ff, numy7_ff;
   logic [31:0]        g7_ff;
   side_d_type         d7_ff;
   logic               vld7_ff;
   side_d_type         d_dly_ff [DIV_STEPS];
   side_d_type         sd;
   logic               dvx_vld, dvy_vld, dvx_ovf, dvy_ovf;
   logic [DIV_STEPS-1:0] qx, qy;
   // T8
   rsp_type            out_in, out_ff;
   logic               vld8_ff;
   clamp_type          cx8, cy8;

   assign busy = 1'b0;

   // ---------------- first unit pair ----------------
   mjo_unit u_unit_a (
      .clock (clock), .reset (reset), .in_valid (vld0_ff),
      .in_x (33'(in_ff.first_dir_x)), .in_y (33'(in_ff.first_dir_y)),
      .out_valid (ua_vld), .out_ux (ua_x), .out_uy (ua_y)
   );

   mjo_unit u_unit_b (
      .clock (clock), .reset (reset), .in_valid (vld0_ff),
      .in_x (33'(in_ff.second_dir_x)), .in_y (33'(in_ff.second_dir_y)),
      .out_valid (ub_vld), .out_ux (ub_x), .out_uy (ub_y)
   );

   // ---------------- T1 / T2 / T3 comb ----------------
   always_comb begin
      ml1_in  = mag32(33'(a_dly_ff[UNIT_LAT-1].hw));
      nay1    = -33'(ua_y);
      zrx_sum = zpx1_ff + (64'd1 << (UNIT_BITS - 1));
      zry_sum = zpy1_ff + (64'd1 << (UNIT_BITS - 1));
      zmx2    = 32'(zrx_sum >> UNIT_BITS);
      zmy2    = 32'(zry_sum >> UNIT_BITS);
      zcx2    = clamp_out({2'b00, zmx2}, zsx1_ff);
      zcy2    = clamp_out({2'b00, zmy2}, zsy1_ff);
      if (zmx2 == 32'd0) zcx2 = '0;
      if (zmy2 == 32'd0) zcy2 = '0;

      b3_in.bx     = s3_ff.bx;
      b3_in.by     = s3_ff.by;
      b3_in.opp    = s3_ff.opp;
      b3_in.flip   = (cxa3_ff - cxb3_ff) < 0;
      b3_in.ml     = s3_ff.ml;
      b3_in.fz     = s3_ff.fz;
      b3_in.zres_x = s3_ff.zres_x;
      b3_in.zres_y = s3_ff.zres_y;
      b3_in.zflag  = s3_ff.zflag;
      b3_in.ax     = s3_ff.ax;
      b3_in.ay     = s3_ff.ay;
   end

   always_ff @(posedge clock) begin
      // T0
      if (start && !busy) in_ff <= req_item;
      a_dly_ff[0].hw <= in_ff.half_width;
      a_dly_ff[0].fz <= (in_ff.first_dir_x == 32'sd0) && (in_ff.first_dir_y == 32'sd0);
      for (int i = 1; i < UNIT_LAT; i++) a_dly_ff[i] <= a_dly_ff[i-1];
      // T1
      ax1_ff  <= ua_x;
      ay1_ff  <= ua_y;
      bx1_ff  <= ub_x;
      by1_ff  <= ub_y;
      ml1_ff  <= ml1_in;
      fz1_ff  <= a_dly_ff[UNIT_LAT-1].fz;
      opp1_ff <= (ua_x == -ub_x) && (ua_y == -ub_y);
      nxp1_ff <= 64'(nay1) * NUDGE_Q30;
      nyp1_ff <= 64'(ua_x) * NUDGE_Q30;
      zpx1_ff <= ml1_in * mag32(33'(ub_y));
      zpy1_ff <= ml1_in * mag32(33'(ub_x));
      // perpendicular is (-by, bx)
      zsx1_ff <= a_dly_ff[UNIT_LAT-1].hw[31] != (ub_y > 32'sd0);
      zsy1_ff <= a_dly_ff[UNIT_LAT-1].hw[31] != ub_x[31];
      // T2
      apx2_ff <= opp1_ff ? 33'(ax1_ff) + round_q30(nxp1_ff) : 33'(ax1_ff);
      apy2_ff <= opp1_ff ? 33'(ay1_ff) + round_q30(nyp1_ff) : 33'(ay1_ff);
      ax2_ff  <= ax1_ff;
      ay2_ff  <= ay1_ff;
      bx2_ff  <= bx1_ff;
      by2_ff  <= by1_ff;
      ml2_ff  <= ml1_ff;
      fz2_ff  <= fz1_ff;
      opp2_ff <= opp1_ff;
      zrx2_ff <= zcx2.val;
      zry2_ff <= zcy2.val;
      zfl2_ff <= zcx2.flag | zcy2.flag;
      // T3
      apx3_ff <= apx2_ff;
      apy3_ff <= apy2_ff;
      smx3_ff <= apx2_ff + 33'(bx2_ff);
      smy3_ff <= apy2_ff + 33'(by2_ff);
      cxa3_ff <= 64'(apx2_ff) * 64'(by2_ff);
      cxb3_ff <= 64'(apy2_ff) * 64'(bx2_ff);
      s3_ff.ax     <= ax2_ff;
      s3_ff.ay     <= ay2_ff;
      s3_ff.bx     <= bx2_ff;
      s3_ff.by     <= by2_ff;
      s3_ff.opp    <= opp2_ff;
      s3_ff.flip   <= 1'b0;
      s3_ff.ml     <= ml2_ff;
      s3_ff.fz     <= fz2_ff;
      s3_ff.zres_x <= zrx2_ff;
      s3_ff.zres_y <= zry2_ff;
      s3_ff.zflag  <= zfl2_ff;
      b_dly_ff[0] <= b3_in;
      for (int i = 1; i < UNIT_LAT; i++) b_dly_ff[i] <= b_dly_ff[i-1];
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld0_ff <= start && !busy;
         vld1_ff <= ua_vld & ub_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   // ---------------- second unit pair ----------------
   mjo_unit u_unit_c (
      .clock (clock), .reset (reset), .in_valid (vld3_ff),
      .in_x (apx3_ff), .in_y (apy3_ff),
      .out_valid (uc_vld), .out_ux (uc_x), .out_uy (uc_y)
   );

   mjo_unit u_unit_d (
      .clock (clock), .reset (reset), .in_valid (vld3_ff),
      .in_x (smx3_ff), .in_y (smy3_ff),
      .out_valid (ud_vld), .out_ux (ud_x), .out_uy (ud_y)
   );

   // ---------------- T4 .. T7 ----------------
   always_comb begin
      sb   = b_dly_ff[UNIT_LAT-1];
      anx4 = sb.opp ? uc_x : sb.ax;
      any4 = sb.opp ? uc_y : sb.ay;
      mux4_in = mag32(33'(ud_x));
      muy4_in = mag32(33'(ud_y));
      c4_in.mm_x   = '0;
      c4_in.mm_y   = '0;
      c4_in.neg_x  = ud_x[31] != sb.flip;
      c4_in.neg_y  = ud_y[31] != sb.flip;
      c4_in.kz_x   = (mux4_in == 32'd0) || (sb.ml == 32'd0);
      c4_in.kz_y   = (muy4_in == 32'd0) || (sb.ml == 32'd0);
      c4_in.fz     = sb.fz;
      c4_in.zres_x = sb.zres_x;
      c4_in.zres_y = sb.zres_y;
      c4_in.zflag  = sb.zflag;
      c5_in        = c4_ff;
      c5_in.mm_x   = mux4_ff * ml4_ff;
      c5_in.mm_y   = muy4_ff * ml4_ff;
      mdx5 = mag32(dx4_ff);
      mdy5 = mag32(dy4_ff);
      sc   = c_dly_ff[ISQRT_STEPS-1];
   end

   always_ff @(posedge clock) begin
      // T4
      dx4_ff  <= 33'(anx4) - 33'(sb.bx);
      dy4_ff  <= 33'(any4) - 33'(sb.by);
      mux4_ff <= mux4_in;
      muy4_ff <= muy4_in;
      ml4_ff  <= sb.ml;
      c4_ff   <= c4_in;
      // T5
      sqx5_ff <= mdx5 * mdx5;
      sqy5_ff <= mdy5 * mdy5;
      c5_ff   <= c5_in;
      // T6
      sum6_ff <= sqx5_ff + sqy5_ff;
      c6_ff   <= c5_ff;
      c_dly_ff[0] <= c6_ff;
      for (int i = 1; i < ISQRT_STEPS; i++) c_dly_ff[i] <= c_dly_ff[i-1];
      // T7
      numx7_ff <= (sc.mm_x << 1) + 64'(g_root >> 1);
      numy7_ff <= (sc.mm_y << 1) + 64'(g_root >> 1);
      g7_ff    <= g_root;
      d7_ff.neg_x  <= sc.neg_x;
      d7_ff.neg_y  <= sc.neg_y;
      d7_ff.kz_x   <= sc.kz_x;
      d7_ff.kz_y   <= sc.kz_y;
      d7_ff.fz     <= sc.fz;
      d7_ff.zres_x <= sc.zres_x;
      d7_ff.zres_y <= sc.zres_y;
      d7_ff.zflag  <= sc.zflag;
      d_dly_ff[0] <= d7_ff;
      for (int i = 1; i < DIV_STEPS; i++) d_dly_ff[i] <= d_dly_ff[i-1];
      // T8
      out_ff <= out_in;
      if (reset) begin
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
         vld8_ff <= 1'b0;
      end else begin
         vld4_ff <= uc_vld & ud_vld;
         vld5_ff <= vld4_ff;
         vld6_ff <= vld5_ff;
         vld7_ff <= g_vld;
         vld8_ff <= dvx_vld & dvy_vld;
      end
   end

   mjo_isqrt u_isqrt_g (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld6_ff),
      .in_value  (sum6_ff),
      .out_valid (g_vld),
      .out_root  (g_root)
   );

   mjo_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld7_ff),
      .in_num    (numx7_ff),
      .in_den    (g7_ff),
      .out_valid (dvx_vld),
      .out_quot  (qx),
      .out_ovf   (dvx_ovf)
   );

   mjo_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld7_ff),
      .in_num    (numy7_ff),
      .in_den    (g7_ff),
      .out_valid (dvy_vld),
      .out_quot  (qy),
      .out_ovf   (dvy_ovf)
   );

   // ---------------- T8: select and clamp ----------------
   always_comb begin
      sd  = d_dly_ff[DIV_STEPS-1];
      cx8 = clamp_out(qx, sd.neg_x);
      cy8 = clamp_out(qy, sd.neg_y);
      if (dvx_ovf) begin
         cx8.flag = 1'b1;
         cx8.val  = sd.neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if (dvy_ovf) begin
         cy8.flag = 1'b1;
         cy8.val  = sd.neg_y ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if (sd.kz_x) cx8 = '0;
      if (sd.kz_y) cy8 = '0;
      if (sd.fz) begin
         out_in.offset_x  = sd.zres_x;
         out_in.offset_y  = sd.zres_y;
         out_in.saturated = sd.zflag;
      end else begin
         out_in.offset_x  = cx8.val;
         out_in.offset_y  = cy8.val;
         out_in.saturated = cx8.flag | cy8.flag;
      end
   end

   assign rsp_valid = vld8_ff;
   assign rsp_item  = out_ff;

endmodule

// ===== tb/mjo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miter join offset checker
// Watches the item and result channels, predicts the miter offset of every
// accepted item and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module mjo_checker import mjo_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  rsp_type rsp_item,
   output int      fail_count,
   output int      pending
);

   localparam logic [63:0] POS_MAX = 64'd2147483647;
   localparam logic [63:0] NEG_MAX = 64'd2147483648;

   rsp_type offset_q[$];

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] magnitude(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint signed_of(input logic [63:0] m, input bit neg);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint round_unit(input longint v);
      logic [63:0] m;
      m = (magnitude(v) + (64'd1 << 29)) >> 30;
      return signed_of(m, v < 0);
   endfunction

   task automatic make_unit(input longint x, input longint y, output longint ux,
                            output longint uy);
      logic [63:0] mx, my, m, len;
      mx = magnitude(x);
      my = magnitude(y);
      m  = mx > my ? mx : my;
      if (m == 0) begin
         ux = 0;
         uy = 0;
         return;
      end
      while (m < (64'd1 << 30)) begin
         mx = mx << 1;
         my = my << 1;
         m  = m << 1;
      end
      while (m >= (64'd1 << 31)) begin
         mx = mx >> 1;
         my = my >> 1;
         m  = m >> 1;
      end
      len = floor_sqrt(mx * mx + my * my);
      ux  = signed_of(((mx << 30) + len / 2) / len, x < 0);
      uy  = signed_of(((my << 30) + len / 2) / len, y < 0);
   endtask

   function automatic longint clamp_component(input logic [63:0] m, input bit neg,
                                              inout bit sat);
      if (neg) begin
         if (m > NEG_MAX) begin
            sat = 1;
            return -longint'(POS_MAX) - 1;
         end
         return -longint'(m);
      end
      if (m > POS_MAX) begin
         sat = 1;
         return longint'(POS_MAX);
      end
      return longint'(m);
   endfunction

   task automatic predict_offset(input req_type r, output rsp_type o);
      longint      x1, y1, x2, y2, hw, ax, ay, bx, by, anx, any, nx, ny, dx, dy;
      longint      u[2];
      longint      res[2];
      logic [63:0] ml, g, m;
      bit          sat, flip, neg;
      x1  = r.first_dir_x;
      y1  = r.first_dir_y;
      x2  = r.second_dir_x;
      y2  = r.second_dir_y;
      hw  = r.half_width;
      ml  = magnitude(hw);
      sat = 0;
      if (x1 == 0 && y1 == 0) begin
         make_unit(-y2, x2, u[0], u[1]);
         for (int k = 0; k < 2; k++) begin
            m = (ml * magnitude(u[k]) + (64'd1 << 29)) >> 30;
            res[k] = m != 0 ? clamp_component(m, (hw < 0) != (u[k] < 0), sat) : 0;
         end
      end else begin
         make_unit(x1, y1, ax, ay);
         make_unit(x2, y2, bx, by);
         anx = ax;
         any = ay;
         if (ax == -bx && ay == -by) begin
            nx = round_unit(-ay * NUDGE_Q30);
            ny = round_unit(ax * NUDGE_Q30);
            ax = ax + nx;
            ay = ay + ny;
            make_unit(ax, ay, anx, any);
         end
         make_unit(ax + bx, ay + by, u[0], u[1]);
         flip = (ax * by - ay * bx) < 0;
         dx   = anx - bx;
         dy   = any - by;
         g    = floor_sqrt(magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy));
         for (int k = 0; k < 2; k++) begin
            neg = (u[k] < 0) != flip;
            if (ml == 0 || u[k] == 0) res[k] = 0;
            else if (g == 0) res[k] = clamp_component(NEG_MAX + 1, neg, sat);
            else res[k] = clamp_component((magnitude(u[k]) * 2 * ml + g / 2) / g, neg, sat);
         end
      end
      o.offset_x  = res[0][31:0];
      o.offset_y  = res[1][31:0];
      o.saturated = sat;
   endtask

   assign pending = offset_q.size();

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (start && !busy) begin
            predict_offset(req_item, want);
            offset_q = {offset_q, want};
         end
         if (rsp_valid) begin
            if (offset_q.size() == 0) begin
               $error("result with no item outstanding");
               errs++;
            end else begin
               want = offset_q.pop_front();
               if (rsp_item.offset_x !== want.offset_x) begin
                  $error("offset_x expected %0d got %0d", want.offset_x, rsp_item.offset_x);
                  errs++;
               end
               if (rsp_item.offset_y !== want.offset_y) begin
                  $error("offset_y expected %0d got %0d", want.offset_y, rsp_item.offset_y);
                  errs++;
               end
               if (rsp_item.saturated !== want.saturated) begin
                  $error("saturated expected %0b got %0b", want.saturated,
                         rsp_item.saturated);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miter join offset testbench
// Directed joints (zero, equal and opposite directions, zero and extreme
// widths) then random joints in bursts; the checker grades every result.
// ----------------------------------------------------------------------------
module tb_top import mjo_pkg::*; ();

   localparam int IDLE_LIMIT = 2000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;
   int      fail_count;
   int      pending;
   int      idle_cycles;
   int      joints_sent;
   int      kind_count[6];

   miter_join_offset dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   mjo_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL miter_join_offset");
            $finish;
         end
      end
   end

   task automatic send_joint(input req_type r);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      joints_sent++;
   endtask

   task automatic pause(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_comp();
      logic signed [31:0] v;
      v = $urandom;
      return v >>> $urandom_range(0, 31);
   endfunction

   function automatic req_type joint(input int ax, input int ay, input int bx, input int by,
                                     input int hw);
      req_type r;
      r.first_dir_x  = ax;
      r.first_dir_y  = ay;
      r.second_dir_x = bx;
      r.second_dir_y = by;
      r.half_width   = hw;
      return r;
   endfunction

   function automatic req_type random_joint(output int kind);
      req_type r;
      int      sh;
      kind = $urandom_range(0, 5);
      r.first_dir_x  = rand_comp();
      r.first_dir_y  = rand_comp();
      r.second_dir_x = rand_comp();
      r.second_dir_y = rand_comp();
      r.half_width   = $urandom_range(0, 3) == 0 ? $urandom : rand_comp();
      sh = $urandom_range(0, 4);
      case (kind)
         0: begin
            r.first_dir_x = 0;
            r.first_dir_y = 0;
         end
         1: begin
            r.second_dir_x = -(r.first_dir_x >>> sh);
            r.second_dir_y = -(r.first_dir_y >>> sh);
         end
         2: begin
            r.second_dir_x = r.first_dir_x >>> sh;
            r.second_dir_y = r.first_dir_y >>> sh;
         end
         3: begin
            r.second_dir_x = 0;
            r.second_dir_y = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      req_type r;
      int      kind;
      int      burst;
      bit      drained;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;
      joints_sent = 0;
      drained     = 1'b0;
      foreach (kind_count[i]) kind_count[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_joint(joint(0, 0, 0, 0, 32'h0001_0000));
      send_joint(joint(0, 0, 32'h0001_0000, 0, 32'h0002_0000));
      send_joint(joint(0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_joint(joint(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
      send_joint(joint(32'h0001_0000, 0, 0, 0, 32'h0001_0000));
      send_joint(joint(32'h8000_0000, 32'h8000_0000, 0, 0, 32'h8000_0000));
      send_joint(joint(32'h0001_0000, 0, 32'h0003_0000, 0, 32'h0001_0000));
      send_joint(joint(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000,
                       32'hFFFF_0000));
      send_joint(joint(32'h0001_0000, 0, 32'hFFFF_0000, 0, 32'h0001_0000));
      send_joint(joint(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0001,
                       32'h7FFF_FFFF));
      send_joint(joint(0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000));
      send_joint(joint(32'h0001_0000, 0, 0, 32'h0001_0000, 0));
      send_joint(joint(32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0001_0000));
      send_joint(joint(32'h0001_0000, 0, 0, 32'hFFFF_0000, 32'hFFFF_0000));
      send_joint(joint(32'h0001_0000, 0, 32'h0001_0000, 32'h0000_0010, 32'h7FFF_FFFF));
      send_joint(joint(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h8000_0000));
      send_joint(joint(1, 0, 32'hFFFF_FFFF, 1, 1));
      send_joint(joint(32'h0003_0000, 32'h0004_0000, 32'hFFFC_0000, 32'h0003_0000,
                       32'h0000_8000));
      pause(300);

      for (int i = 0; i < 1800; ) begin
         if (!drained && i >= 900) begin
            drained = 1'b1;
            start <= 1'b0;
            while (pending != 0) @(posedge clock);
         end
         burst = $urandom_range(0, 3) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 12);
         for (int j = 0; j < burst && i < 1800; j++, i++) begin
            r = random_joint(kind);
            kind_count[kind]++;
            send_joint(r);
         end
         pause($urandom_range(1, 15));
      end

      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      $display("%0d joints: %0d zero incoming, %0d opposite, %0d parallel, %0d zero outgoing,",
               joints_sent, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
      $display("%0d general; bursts with random gaps and one full drain", kind_count[4] +
               kind_count[5]);
      if (fail_count == 0) begin
         $display("PASS miter_join_offset");
      end else begin
         $display("FAIL miter_join_offset");
      end
      $finish;
   end

endmodule
